// ----- rtl/core/vbtc_pkg.sv -----
// Shared types, constants and band tables of the VFO band tuning controller.
`default_nettype none

package vbtc_pkg;

  localparam int unsigned NumBands = 11;
  localparam int unsigned FreqW    = 25;
  localparam int unsigned BandW    = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned HostW    = 26;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned CorrW    = 12;
  localparam int unsigned CalcW    = 28;
  localparam int unsigned MemW     = FreqW + ModeW;

  typedef logic [FreqW-1:0]        freq_t;
  typedef logic [BandW-1:0]        band_t;
  typedef logic [ModeW-1:0]        mode_t;
  typedef logic signed [CalcW-1:0] calc_t;
  typedef logic signed [CorrW-1:0] corr_t;

  typedef enum logic [1:0] {
    OP_TUNE = 2'd0,
    OP_BAND = 2'd1,
    OP_HOST = 2'd2
  } op_e;

  localparam band_t LastBand       = band_t'(NumBands - 1);
  localparam band_t BandLimit      = band_t'(NumBands);
  localparam mode_t ModeSideA      = 2'd0;
  localparam mode_t ModeSideB      = 2'd1;
  localparam calc_t SidebandOffset = 28'sd1500;

  function automatic freq_t edge_lo(band_t b);
    freq_t f;
    unique case (b)
      4'd0:    f = 25'd1800000;
      4'd1:    f = 25'd3500000;
      4'd2:    f = 25'd7000000;
      4'd3:    f = 25'd10100000;
      4'd4:    f = 25'd14000000;
      4'd5:    f = 25'd18068000;
      4'd6:    f = 25'd21000000;
      4'd7:    f = 25'd24890000;
      4'd8:    f = 25'd28000000;
      4'd9:    f = 25'd28500000;
      default: f = 25'd29000000;
    endcase
    return f;
  endfunction

  function automatic freq_t edge_hi(band_t b);
    freq_t f;
    unique case (b)
      4'd0:    f = 25'd2000000;
      4'd1:    f = 25'd4000000;
      4'd2:    f = 25'd7300000;
      4'd3:    f = 25'd10150000;
      4'd4:    f = 25'd14350000;
      4'd5:    f = 25'd18168000;
      4'd6:    f = 25'd21450000;
      4'd7:    f = 25'd24990000;
      4'd8:    f = 25'd28500000;
      4'd9:    f = 25'd29000000;
      default: f = 25'd29700000;
    endcase
    return f;
  endfunction

  function automatic corr_t osc_corr(band_t b);
    corr_t c;
    unique case (b)
      4'd0:    c = -12'sd350;
      4'd1:    c = 12'sd0;
      4'd2:    c = 12'sd50;
      4'd3:    c = 12'sd200;
      4'd4:    c = 12'sd500;
      4'd5:    c = 12'sd500;
      4'd6:    c = 12'sd750;
      4'd7:    c = 12'sd750;
      4'd8:    c = 12'sd750;
      4'd9:    c = 12'sd750;
      default: c = 12'sd200;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vbtc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vbtc_ram #(
  parameter int unsigned Width = vbtc_pkg::MemW,
  parameter int unsigned Depth = vbtc_pkg::NumBands,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vbtc_band_pick.sv -----
// Band lookup for a host frequency: first band whose edges contain it, else the last band.
`default_nettype none

module vbtc_band_pick (
  input  wire logic [vbtc_pkg::HostW-1:0] host_freq_i,
  output vbtc_pkg::band_t                 band_o
);

  logic [vbtc_pkg::NumBands-2:0] hit;

  // Compare against every band but the last; the last is the fallback.
  always_comb begin
    for (int i = 0; i < vbtc_pkg::NumBands - 1; i++) begin
      hit[i] = (host_freq_i >= {1'b0, vbtc_pkg::edge_lo(vbtc_pkg::band_t'(i))}) &&
               (host_freq_i <= {1'b0, vbtc_pkg::edge_hi(vbtc_pkg::band_t'(i))});
    end
  end

  // Take the lowest matching band.
  always_comb begin
    band_o = vbtc_pkg::LastBand;
    for (int i = vbtc_pkg::NumBands - 2; i >= 0; i--) begin
      if (hit[i]) begin
        band_o = vbtc_pkg::band_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vfo_band_tuning_controller.sv -----
// Top level of the VFO band tuning controller.
`default_nettype none

// The controller keeps the active dial frequency, band (0..10) and mode, and
// an eleven-slot band memory with one frequency and mode per band. Each input
// transaction (tune step, band change, host set frequency) yields exactly one
// output transaction carrying the active state after the command and the
// oscillator frequency (dial plus a fixed per-band correction). On accept, a
// valid band change or host set frequency writes the old band's slot and reads
// the new band's slot from the band RAM; in the execute state the block then
// clamps and commits the new state once the output register is free. One item
// is in flight at a time. The active state registers double as the output
// register, so an item can be accepted while the previous result still waits
// to be taken. The band RAM needs no clearing pass: a valid bit per slot
// stands in for its reset value (lower band edge, mode zero), so the block is
// ready right after reset.

module vfo_band_tuning_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic signed [vbtc_pkg::DeltaW-1:0] tune_delta_i,
  input  wire logic [vbtc_pkg::BandW-1:0]    new_band_i,
  input  wire logic [vbtc_pkg::HostW-1:0]    host_freq_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [vbtc_pkg::FreqW-1:0]         dial_freq_o,
  output logic [vbtc_pkg::FreqW-1:0]         oscillator_freq_o,
  output logic [vbtc_pkg::BandW-1:0]         band_o,
  output logic [vbtc_pkg::ModeW-1:0]         mode_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                state_q;
  vbtc_pkg::freq_t       active_freq_q;
  vbtc_pkg::band_t       active_band_q;
  vbtc_pkg::mode_t       active_mode_q;
  logic                  out_valid_q;
  logic [vbtc_pkg::NumBands-1:0] slot_valid_q;

  // Latched command, held from accept until commit.
  vbtc_pkg::op_e                      op_q;
  logic signed [vbtc_pkg::DeltaW-1:0] delta_q;
  logic [vbtc_pkg::HostW-1:0]         host_q;
  vbtc_pkg::band_t                    tgt_q;
  logic                               switch_q;
  logic                               same_q;
  logic                               hit_q;

  // Accept-side decode.
  logic            accept;
  vbtc_pkg::op_e   op_in;
  vbtc_pkg::band_t picked_band;
  vbtc_pkg::band_t tgt_d;
  logic            switch_d;
  logic            hit_d;

  // Commit-side datapath.
  logic [vbtc_pkg::MemW-1:0] ram_rdata;
  logic            commit;
  vbtc_pkg::freq_t slot_freq;
  vbtc_pkg::mode_t slot_mode;
  vbtc_pkg::band_t band_d;
  vbtc_pkg::mode_t mode_d;
  vbtc_pkg::calc_t cand;
  vbtc_pkg::calc_t lo_edge;
  vbtc_pkg::calc_t hi_edge;
  vbtc_pkg::freq_t freq_d;
  logic signed [vbtc_pkg::FreqW:0] osc_sum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign op_in      = vbtc_pkg::op_e'(operation_i);

  vbtc_band_pick u_band_pick (
    .host_freq_i (host_freq_i),
    .band_o      (picked_band)
  );

  // Pick the slot to load; a band change beyond the last band does nothing.
  always_comb begin
    tgt_d    = new_band_i;
    switch_d = 1'b0;
    case (op_in)
      vbtc_pkg::OP_BAND: begin
        switch_d = (new_band_i < vbtc_pkg::BandLimit);
      end
      vbtc_pkg::OP_HOST: begin
        tgt_d    = picked_band;
        switch_d = 1'b1;
      end
      default: begin
        switch_d = 1'b0;
      end
    endcase
    hit_d = switch_d && slot_valid_q[tgt_d];
  end

  // Save the active state into the old slot and fetch the new one in the
  // same cycle. A change to the same band reloads what is being saved; that
  // case is forwarded from the active registers instead of the RAM.
  vbtc_ram #(
    .Width (vbtc_pkg::MemW),
    .Depth (vbtc_pkg::NumBands)
  ) u_band_ram (
    .clk_i   (clk_i),
    .we_i    (accept && switch_d),
    .waddr_i (active_band_q),
    .wdata_i ({active_freq_q, active_mode_q}),
    .re_i    (accept && switch_d),
    .raddr_i (tgt_d),
    .rdata_o (ram_rdata)
  );

  // Commit only when the output register is empty or being emptied.
  assign commit = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (same_q) begin
      slot_freq = active_freq_q;
      slot_mode = active_mode_q;
    end else if (hit_q) begin
      slot_freq = ram_rdata[vbtc_pkg::MemW-1:vbtc_pkg::ModeW];
      slot_mode = ram_rdata[vbtc_pkg::ModeW-1:0];
    end else begin
      // Untouched slot: lower band edge, mode zero.
      slot_freq = vbtc_pkg::edge_lo(tgt_q);
      slot_mode = vbtc_pkg::ModeSideA;
    end

    band_d = switch_q ? tgt_q : active_band_q;
    mode_d = switch_q ? slot_mode : active_mode_q;

    case (op_q)
      vbtc_pkg::OP_TUNE: begin
        cand = $signed({3'b000, active_freq_q}) + vbtc_pkg::CalcW'(delta_q);
      end
      vbtc_pkg::OP_BAND: begin
        cand = switch_q ? $signed({3'b000, slot_freq}) : $signed({3'b000, active_freq_q});
      end
      vbtc_pkg::OP_HOST: begin
        // Apply the sideband offset of the freshly loaded mode.
        if (mode_d == vbtc_pkg::ModeSideA) begin
          cand = $signed({2'b00, host_q}) + vbtc_pkg::SidebandOffset;
        end else if (mode_d == vbtc_pkg::ModeSideB) begin
          cand = $signed({2'b00, host_q}) - vbtc_pkg::SidebandOffset;
        end else begin
          cand = $signed({2'b00, host_q});
        end
      end
      default: begin
        cand = $signed({3'b000, active_freq_q});
      end
    endcase

    // Clamp to the edges of the resulting band.
    lo_edge = $signed({3'b000, vbtc_pkg::edge_lo(band_d)});
    hi_edge = $signed({3'b000, vbtc_pkg::edge_hi(band_d)});
    if (cand < lo_edge) begin
      freq_d = lo_edge[vbtc_pkg::FreqW-1:0];
    end else if (cand > hi_edge) begin
      freq_d = hi_edge[vbtc_pkg::FreqW-1:0];
    end else begin
      freq_d = cand[vbtc_pkg::FreqW-1:0];
    end
  end

  // Control state and the active registers, which also form the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_freq_q <= vbtc_pkg::edge_lo(vbtc_pkg::band_t'(0));
      active_band_q <= '0;
      active_mode_q <= vbtc_pkg::ModeSideA;
      out_valid_q   <= 1'b0;
      slot_valid_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
            if (switch_d) begin
              slot_valid_q[active_band_q] <= 1'b1;
            end
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (commit) begin
        active_freq_q <= freq_d;
        active_band_q <= band_d;
        active_mode_q <= mode_d;
        out_valid_q   <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // Hold the command payload from accept to commit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_in;
      delta_q  <= tune_delta_i;
      host_q   <= host_freq_i;
      tgt_q    <= tgt_d;
      switch_q <= switch_d;
      same_q   <= switch_d && (tgt_d == active_band_q);
      hit_q    <= hit_d;
    end
  end

  // Oscillator frequency follows the held dial frequency and band.
  assign osc_sum = $signed({1'b0, active_freq_q})
                 + (vbtc_pkg::FreqW + 1)'(vbtc_pkg::osc_corr(active_band_q));

  assign out_valid_o       = out_valid_q;
  assign dial_freq_o       = active_freq_q;
  assign oscillator_freq_o = osc_sum[vbtc_pkg::FreqW-1:0];
  assign band_o            = active_band_q;
  assign mode_o            = active_mode_q;

endmodule

`default_nettype wire

// ----- rtl/core/vbtc_checker.sv -----
// Port-level checks of the VFO band tuning controller and their binding.
`default_nettype none

module vbtc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic [1:0]                    operation_i,
  input wire logic signed [vbtc_pkg::DeltaW-1:0] tune_delta_i,
  input wire logic [vbtc_pkg::BandW-1:0]    new_band_i,
  input wire logic [vbtc_pkg::HostW-1:0]    host_freq_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [vbtc_pkg::FreqW-1:0]    dial_freq_o,
  input wire logic [vbtc_pkg::FreqW-1:0]    oscillator_freq_o,
  input wire logic [vbtc_pkg::BandW-1:0]    band_o,
  input wire logic [vbtc_pkg::ModeW-1:0]    mode_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(dial_freq_o) && $stable(band_o) &&
                                   $stable(mode_o) && $stable(oscillator_freq_o))
    else $error("stalled result changed");

  // One command in flight: the cycle after an accept takes no input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command accepted while one is in flight");

  // The active band stays within the band list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_o <= vbtc_pkg::LastBand)
    else $error("band out of range");

  // The dial frequency stays within the outer band edges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dial_freq_o >= vbtc_pkg::edge_lo(vbtc_pkg::band_t'(0)) &&
    dial_freq_o <= vbtc_pkg::edge_hi(vbtc_pkg::LastBand))
    else $error("dial frequency outside band edges");

endmodule

bind vfo_band_tuning_controller vbtc_checker u_vbtc_checker (.*);

`default_nettype wire
